@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL modules
// Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond at one edge implies expr at the next edge
`define ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

@@ sv/apsp_pkg.sv @@
// ----------------------------------------------------------------------------
// apsp_pkg
// Types and constants of the all-pairs shortest path core.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int DIST_W           = 24;
    localparam int VC_W             = 7;
    localparam int IDX_W            = 6;
    localparam int WEIGHT_W         = 16;
    localparam int FUNC_W           = 2;

    localparam logic [DIST_W-1:0] DIST_INF = 24'hFF_FFFF;
    localparam logic [VC_W-1:0]   VC_RESET = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FN_WRITE = 2'd0,
        FN_RUN   = 2'd1,
        FN_READ  = 2'd2,
        FN_NOP   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_WRITE,
        DP_READ,
        DP_LEG,
        DP_CELL
    } dp_op_t;

    typedef enum logic [1:0] {
        RES_ACK,
        RES_NONE,
        RES_READ,
        RES_MISS
    } res_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LEG,
        ST_ROW,
        ST_RESULT
    } state_t;

    typedef struct packed {
        dp_op_t    op;
        logic      load_out;
        res_kind_t kind;
    } dp_ctrl_t;

    typedef struct packed {
        logic slot_free;
    } dp_stat_t;

endpackage

@@ sv/apsp_in_if.sv @@
// ----------------------------------------------------------------------------
// apsp_in_if
// Input channel: one item word with valid/ready.
// ----------------------------------------------------------------------------
interface apsp_in_if;

    logic                           valid;
    logic                           ready;
    logic [apsp_pkg::FUNC_W-1:0]    func;
    logic [apsp_pkg::IDX_W-1:0]     row;
    logic [apsp_pkg::IDX_W-1:0]     col;
    logic [apsp_pkg::WEIGHT_W-1:0]  weight;
    logic                           no_edge;

    modport source (output valid, func, row, col, weight, no_edge, input ready);
    modport sink   (input valid, func, row, col, weight, no_edge, output ready);

endinterface

@@ sv/apsp_out_if.sv @@
// ----------------------------------------------------------------------------
// apsp_out_if
// Result channel: one result word with valid/ready.
// ----------------------------------------------------------------------------
interface apsp_out_if;

    logic                         valid;
    logic                         ready;
    logic [apsp_pkg::DIST_W-1:0]  distance;
    logic                         unreachable;
    logic                         done_res;

    modport source (output valid, distance, unreachable, done_res, input ready);
    modport sink   (input valid, distance, unreachable, done_res, output ready);

endinterface

@@ sv/apsp_dp.sv @@
// ----------------------------------------------------------------------------
// apsp_dp
// Datapath: distance memory, relaxation compare and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apsp_dp #(
    parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  apsp_pkg::dp_ctrl_t                   ctrl,
    output apsp_pkg::dp_stat_t                   stat,
    input  logic [$clog2(MAX_VERTICES)-1:0]      a_row,
    input  logic [$clog2(MAX_VERTICES)-1:0]      a_col,
    input  logic [$clog2(MAX_VERTICES)-1:0]      b_row,
    input  logic [$clog2(MAX_VERTICES)-1:0]      b_col,
    input  logic [apsp_pkg::WEIGHT_W-1:0]        weight,
    input  logic                                 no_edge,
    apsp_out_if.source                           out_ch
);

    localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = apsp_pkg::DIST_W;

    logic [DW-1:0] mem [DEPTH];

    logic [AW-1:0] addr_a;
    logic [AW-1:0] addr_b;
    logic [DW-1:0] wr_data;
    logic [DW:0]   sum;
    logic          upd;

    logic [DW-1:0] rda_reg;
    logic [DW-1:0] rdb_reg;
    logic [DW-1:0] leg1_reg;
    logic [AW-1:0] wb_addr_reg;
    logic          cell_pend_reg;
    logic          cell_pend_next;
    logic          leg_pend_reg;
    logic          leg_pend_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [DW-1:0] dist_out_reg;
    logic [DW-1:0] dist_out_next;
    logic          unreach_reg;
    logic          unreach_next;
    logic          done_reg;
    logic          done_next;

    assign addr_a  = AW'(a_row) * AW'(MAX_VERTICES) + AW'(a_col);
    assign addr_b  = AW'(b_row) * AW'(MAX_VERTICES) + AW'(b_col);
    assign wr_data = no_edge ? apsp_pkg::DIST_INF
                             : {{(DW-apsp_pkg::WEIGHT_W){1'b0}}, weight};

    // leg2 = (k,j) on port A, current = (i,j) on port B
    assign sum = {1'b0, leg1_reg} + {1'b0, rda_reg};
    assign upd = cell_pend_reg && (leg1_reg != apsp_pkg::DIST_INF)
              && (rda_reg != apsp_pkg::DIST_INF) && (sum < {1'b0, rdb_reg});

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            mem[wb_addr_reg] <= sum[DW-1:0];
        end
        else if (ctrl.op == apsp_pkg::DP_WRITE)
        begin
            mem[addr_a] <= wr_data;
        end
        if (ctrl.op == apsp_pkg::DP_READ || ctrl.op == apsp_pkg::DP_LEG
            || ctrl.op == apsp_pkg::DP_CELL)
        begin
            rda_reg <= mem[addr_a];
        end
        if (ctrl.op == apsp_pkg::DP_CELL)
        begin
            rdb_reg     <= mem[addr_b];
            wb_addr_reg <= addr_b;
        end
        if (leg_pend_reg)
        begin
            leg1_reg <= rda_reg;
        end
    end

    assign cell_pend_next = (ctrl.op == apsp_pkg::DP_CELL);
    assign leg_pend_next  = (ctrl.op == apsp_pkg::DP_LEG);

    always_comb
    begin
        dist_out_next = '0;
        unreach_next  = 1'b0;
        done_next     = 1'b0;
        case (ctrl.kind)
            apsp_pkg::RES_ACK:
            begin
                done_next = 1'b1;
            end
            apsp_pkg::RES_READ:
            begin
                done_next     = 1'b1;
                unreach_next  = (rda_reg == apsp_pkg::DIST_INF);
                dist_out_next = unreach_next ? '0 : rda_reg;
            end
            apsp_pkg::RES_MISS:
            begin
                done_next    = 1'b1;
                unreach_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign stat.slot_free = !out_valid_reg || out_ch.ready;
    assign out_valid_next = ctrl.load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_pend_reg <= 1'b0;
            leg_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cell_pend_reg <= cell_pend_next;
            leg_pend_reg  <= leg_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            dist_out_reg <= dist_out_next;
            unreach_reg  <= unreach_next;
            done_reg     <= done_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.distance    = dist_out_reg;
    assign out_ch.unreachable = unreach_reg;
    assign out_ch.done_res    = done_reg;

    `ASSERT_NEXT(a_cell_pend_src, ctrl.op == apsp_pkg::DP_CELL, cell_pend_reg, "cell compare lost")
    `ASSERT_CLK(a_no_write_clash, !(cell_pend_reg && ctrl.op == apsp_pkg::DP_WRITE), "write port clash")

endmodule

@@ sv/apsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// apsp_ctrl
// Controller: item decode, k/i/j sequencer and vertex count register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apsp_ctrl #(
    parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [apsp_pkg::VC_W-1:0]            cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [apsp_pkg::FUNC_W-1:0]          func,
    input  logic [apsp_pkg::IDX_W-1:0]           row,
    input  logic [apsp_pkg::IDX_W-1:0]           col,
    output apsp_pkg::dp_ctrl_t                   ctrl,
    input  apsp_pkg::dp_stat_t                   stat,
    output logic [$clog2(MAX_VERTICES)-1:0]      a_row,
    output logic [$clog2(MAX_VERTICES)-1:0]      a_col,
    output logic [$clog2(MAX_VERTICES)-1:0]      b_row,
    output logic [$clog2(MAX_VERTICES)-1:0]      b_col
);

    localparam int IW = $clog2(MAX_VERTICES);

    apsp_pkg::state_t    state_reg;
    apsp_pkg::state_t    state_next;
    apsp_pkg::res_kind_t kind_reg;
    apsp_pkg::res_kind_t kind_next;

    logic [apsp_pkg::VC_W-1:0] vc_reg;
    logic [IW-1:0] k_reg;
    logic [IW-1:0] k_next;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] i_next;
    logic [IW-1:0] j_reg;
    logic [IW-1:0] j_next;

    logic [8:0]    n_eff;
    logic [IW-1:0] last_idx;
    logic          in_range;
    logic          accept;

    always_comb
    begin
        if (vc_reg == '0)
        begin
            n_eff = 9'd1;
        end
        else if ({2'b00, vc_reg} > 9'(MAX_VERTICES))
        begin
            n_eff = 9'(MAX_VERTICES);
        end
        else
        begin
            n_eff = {2'b00, vc_reg};
        end
    end

    assign last_idx = IW'(n_eff - 9'd1);
    assign in_range = ({3'b000, row} < n_eff) && ({3'b000, col} < n_eff);
    assign in_ready = (state_reg == apsp_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        ctrl.op       = apsp_pkg::DP_NOP;
        ctrl.load_out = 1'b0;
        ctrl.kind     = kind_reg;
        a_row         = IW'(row);
        a_col         = IW'(col);
        b_row         = i_reg;
        b_col         = j_reg;
        case (state_reg)
            apsp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (apsp_pkg::func_t'(func))
                        apsp_pkg::FN_WRITE:
                        begin
                            if (in_range)
                            begin
                                ctrl.op = apsp_pkg::DP_WRITE;
                            end
                            kind_next = apsp_pkg::RES_ACK;
                        end
                        apsp_pkg::FN_RUN:
                        begin
                            kind_next = apsp_pkg::RES_ACK;
                        end
                        apsp_pkg::FN_READ:
                        begin
                            if (in_range)
                            begin
                                ctrl.op   = apsp_pkg::DP_READ;
                                kind_next = apsp_pkg::RES_READ;
                            end
                            else
                            begin
                                kind_next = apsp_pkg::RES_MISS;
                            end
                        end
                        default:
                        begin
                            kind_next = apsp_pkg::RES_NONE;
                        end
                    endcase
                    ctrl.kind = kind_next;
                    if (apsp_pkg::func_t'(func) == apsp_pkg::FN_RUN)
                    begin
                        k_next     = '0;
                        i_next     = '0;
                        state_next = apsp_pkg::ST_LEG;
                    end
                    else if (kind_next == apsp_pkg::RES_READ)
                    begin
                        state_next = apsp_pkg::ST_READ;
                    end
                    else if (stat.slot_free)
                    begin
                        ctrl.load_out = 1'b1;
                    end
                    else
                    begin
                        state_next = apsp_pkg::ST_RESULT;
                    end
                end
            end
            apsp_pkg::ST_READ:
            begin
                if (stat.slot_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = apsp_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = apsp_pkg::ST_RESULT;
                end
            end
            apsp_pkg::ST_LEG:
            begin
                ctrl.op    = apsp_pkg::DP_LEG;
                a_row      = i_reg;
                a_col      = k_reg;
                j_next     = '0;
                state_next = apsp_pkg::ST_ROW;
            end
            apsp_pkg::ST_ROW:
            begin
                ctrl.op = apsp_pkg::DP_CELL;
                a_row   = k_reg;
                a_col   = j_reg;
                if (j_reg == last_idx)
                begin
                    if (i_reg == last_idx)
                    begin
                        if (k_reg == last_idx)
                        begin
                            state_next = apsp_pkg::ST_RESULT;
                        end
                        else
                        begin
                            k_next     = k_reg + 1'b1;
                            i_next     = '0;
                            state_next = apsp_pkg::ST_LEG;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = apsp_pkg::ST_LEG;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            apsp_pkg::ST_RESULT:
            begin
                if (stat.slot_free)
                begin
                    ctrl.load_out = 1'b1;
                    state_next    = apsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = apsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apsp_pkg::ST_IDLE;
            kind_reg  <= apsp_pkg::RES_NONE;
            vc_reg    <= apsp_pkg::VC_RESET;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (cfg_we)
            begin
                vc_reg <= cfg_wdata;
            end
        end
    end

    `ASSERT_CLK(a_load_free, !ctrl.load_out || stat.slot_free, "result loaded into full slot")
    `ASSERT_CLK(a_j_bound, (state_reg != apsp_pkg::ST_ROW) || (j_reg <= last_idx), "column past end")
    `ASSERT_NEXT(a_run_start, accept && (func == apsp_pkg::FN_RUN), state_reg == apsp_pkg::ST_LEG, "run did not start")

endmodule

@@ sv/all_pairs_shortest_path_core.sv @@
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_core: write/read items, a read through ST_READ; output register.
// Run: one relaxation per cycle within a row, a leg fetch before each row, on the
// dual-read-port distance memory. Async reset; matrix not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module all_pairs_shortest_path_core #(
    parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [apsp_pkg::VC_W-1:0]   cfg_wdata,
    apsp_in_if.sink                     in_ch,
    apsp_out_if.source                  out_ch
);

    localparam int IW = $clog2(MAX_VERTICES);

    apsp_pkg::dp_ctrl_t ctrl;
    apsp_pkg::dp_stat_t stat;
    logic [IW-1:0]      a_row;
    logic [IW-1:0]      a_col;
    logic [IW-1:0]      b_row;
    logic [IW-1:0]      b_col;

    apsp_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .func      (in_ch.func),
        .row       (in_ch.row),
        .col       (in_ch.col),
        .ctrl      (ctrl),
        .stat      (stat),
        .a_row     (a_row),
        .a_col     (a_col),
        .b_row     (b_row),
        .b_col     (b_col)
    );

    apsp_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .stat    (stat),
        .a_row   (a_row),
        .a_col   (a_col),
        .b_row   (b_row),
        .b_col   (b_col),
        .weight  (in_ch.weight),
        .no_edge (in_ch.no_edge),
        .out_ch  (out_ch)
    );

    `ASSERT_CLK(a_busy_no_op, in_ch.ready || !(ctrl.op == apsp_pkg::DP_WRITE), "write while busy")

endmodule
